// ----- sv/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_dp and sorted_priority_queue_core; depends on nothing.
`default_nettype none

package spq_pkg;

    // field widths
    localparam int DATA_W        = 32;
    localparam int PRIO_W        = 32;
    localparam int COUNT_OUT_W   = 5;
    localparam int STATUS_W      = 2;

    // default store depth
    localparam int CAPACITY_DEF  = 16;

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_POP = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic push;   // insert the incoming entry
        logic pop;    // remove the head entry into the result
        logic load;   // capture a new result
    } spq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
    } spq_flags_t;

endpackage

`default_nettype wire

// ----- sv/spq_ctrl.sv -----
// Controller for the sorted priority queue: input and result handshake,
// command decode and status code. Depends on spq_pkg.
`default_nettype none

module spq_ctrl
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    input  wire spq_pkg::spq_flags_t           flags,
    output spq_pkg::spq_cmd_t                  cmd,
    output logic [spq_pkg::STATUS_W-1:0]       status,
    output logic                               out_valid
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [spq_pkg::STATUS_W-1:0]    status_reg;
    logic [spq_pkg::STATUS_W-1:0]    status_next;
    logic                            pop_ok_reg;
    logic                            pop_ok_next;
    logic                            accept;
    logic                            res_taken;

    // handshake
    assign in_stall  = (state_reg == S_HOLD) && res_stall;
    assign accept    = in_valid && !in_stall;
    assign res_valid = (state_reg == S_HOLD);
    assign res_taken = res_valid && !res_stall;

    // command decode
    always_comb
    begin
        cmd.load = accept;
        cmd.push = accept && (req_type == spq_pkg::REQ_PUSH) && !flags.full;
        cmd.pop  = accept && (req_type == spq_pkg::REQ_POP) && !flags.empty;
    end

    // next state and result status
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        priority if (accept)
        begin
            state_next  = S_HOLD;
            pop_ok_next = cmd.pop;
            unique case (req_type)
                spq_pkg::REQ_PUSH:
                    status_next = flags.full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
                spq_pkg::REQ_POP:
                    status_next = flags.empty ? spq_pkg::ST_EMPTY_POP : spq_pkg::ST_DONE;
                default:
                    status_next = spq_pkg::ST_DONE;
            endcase
        end
        else if (res_taken)
        begin
            state_next = S_IDLE;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= spq_pkg::ST_DONE;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    assign status    = status_reg;
    assign out_valid = pop_ok_reg;

endmodule

`default_nettype wire

// ----- sv/spq_dp.sv -----
// Datapath for the sorted priority queue: a row of sorted cells that
// compare and shift in parallel, the entry count and the result registers.
// Depends on spq_pkg.
`default_nettype none

module spq_dp
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire spq_pkg::spq_cmd_t                 cmd,
    input  wire logic [spq_pkg::DATA_W-1:0]        item_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] item_priority,
    output spq_pkg::spq_flags_t                    flags,
    output logic [spq_pkg::DATA_W-1:0]             out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]      out_priority,
    output logic [spq_pkg::COUNT_OUT_W-1:0]        entry_count
);

    logic [spq_pkg::DATA_W-1:0]        val_reg   [CAPACITY];
    logic [spq_pkg::DATA_W-1:0]        val_next  [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg  [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] prio_next [CAPACITY];
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [spq_pkg::DATA_W-1:0]        res_value_reg;
    logic signed [spq_pkg::PRIO_W-1:0] res_prio_reg;
    logic [CAPACITY-1:0]               behind;
    logic [CAPACITY-1:0]               take_new;

    // fullness flags
    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_reg == CNT_W'(CAPACITY));

    // per cell: new entry goes ahead of this cell (or cell is unused)
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            behind[i] = (CNT_W'(i) >= count_reg) || (item_priority > prio_reg[i]);
        end
        take_new[0] = behind[0];
        for (int i = 1; i < CAPACITY; i++)
        begin
            take_new[i] = behind[i] && !behind[i-1];
        end
    end

    // cell next values
    always_comb
    begin
        val_next  = val_reg;
        prio_next = prio_reg;
        if (cmd.push)
        begin
            if (take_new[0])
            begin
                val_next[0]  = item_value;
                prio_next[0] = item_priority;
            end
            for (int i = 1; i < CAPACITY; i++)
            begin
                if (take_new[i])
                begin
                    val_next[i]  = item_value;
                    prio_next[i] = item_priority;
                end
                else if (behind[i-1])
                begin
                    val_next[i]  = val_reg[i-1];
                    prio_next[i] = prio_reg[i-1];
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                val_next[i]  = val_reg[i+1];
                prio_next[i] = prio_reg[i+1];
            end
        end
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // cell storage
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        prio_reg <= prio_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_value_reg <= cmd.pop ? val_reg[0] : '0;
            res_prio_reg  <= cmd.pop ? prio_reg[0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign out_value    = res_value_reg;
    assign out_priority = res_prio_reg;
    assign entry_count  = spq_pkg::COUNT_OUT_W'(count_reg);

endmodule

`default_nettype wire

// ----- sv/sorted_priority_queue_core.sv -----
// Top level of the sorted priority queue: controller plus cell datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Usage:
//   Input channel in_valid/in_stall carries req_type, item_value and
//   item_priority; an item is taken on an edge with in_valid high and
//   in_stall low. A push inserts after all entries of equal or higher
//   priority; a pop removes the head entry.
//   Result channel res_valid/res_stall carries status, out_valid, out_value,
//   out_priority and entry_count; one result for every item.
//   Latency: the result is shown the cycle after the item is taken.
//   Throughput: one item per cycle while no result is stalled; every cell
//   compares against the new priority and shifts in the same cycle, so the cell row sets the rate.
//   A stalled result holds, and in_stall is raised until it is taken; an
//   item may enter on the same edge that the waiting result leaves.
//   Reset empties the queue (count zero) and drops any pending result;
//   cell contents are not cleared.
`default_nettype none

module sorted_priority_queue_core
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              req_type,
    input  wire logic [spq_pkg::DATA_W-1:0]        item_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] item_priority,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [spq_pkg::STATUS_W-1:0]           status,
    output logic                                   out_valid,
    output logic [spq_pkg::DATA_W-1:0]             out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]      out_priority,
    output logic [spq_pkg::COUNT_OUT_W-1:0]        entry_count
);

    spq_pkg::spq_cmd_t   cmd;
    spq_pkg::spq_flags_t flags;

    // handshake and command control
    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .flags     (flags),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid)
    );

    // sorted cell row
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item_value    (item_value),
        .item_priority (item_priority),
        .flags         (flags),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .entry_count   (entry_count)
    );

    // a taken item always produces a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> res_valid)
    else $error("result missing after accepted item");

    // a returned entry always carries done status
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid) |-> (status == spq_pkg::ST_DONE))
    else $error("popped entry with error status");

    // a successful push grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (entry_count == spq_pkg::COUNT_OUT_W'($past(entry_count) + 1'b1)))
    else $error("count not advanced on push");

    // push and pop never issued together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
    else $error("push and pop commanded together");

endmodule

`default_nettype wire

// ----- verif/sorted_priority_queue_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue_core: random push/pop traffic
// checked against a shadow copy of the sorted store. Depends on spq_pkg and the core.

module sorted_priority_queue_core_tb;

    localparam int RUN_LIMIT   = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 200;
    localparam int CALM_FROM   = 400;
    localparam int CALM_TO     = 520;
    localparam int PHASE_LEN   = 35;
    localparam int RAND_ITEMS  = 700;

    typedef struct {
        logic                              req;
        logic [spq_pkg::DATA_W-1:0]        value;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
    } pq_req_t;

    typedef struct {
        logic [spq_pkg::STATUS_W-1:0]      status;
        logic                              hit;
        logic [spq_pkg::DATA_W-1:0]        value;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        logic [spq_pkg::COUNT_OUT_W-1:0]   count;
    } pq_res_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic                              req_type = spq_pkg::REQ_PUSH;
    logic [spq_pkg::DATA_W-1:0]        item_value = '0;
    logic signed [spq_pkg::PRIO_W-1:0] item_priority = '0;
    logic                              res_valid;
    logic                              res_stall = 1'b0;
    logic [spq_pkg::STATUS_W-1:0]      status;
    logic                              out_valid;
    logic [spq_pkg::DATA_W-1:0]        out_value;
    logic signed [spq_pkg::PRIO_W-1:0] out_priority;
    logic [spq_pkg::COUNT_OUT_W-1:0]   entry_count;

    // stimulus backlog and outstanding expected results
    pq_req_t req_backlog[$];
    pq_res_t pending_results[$];

    // shadow copy of the store
    logic [spq_pkg::DATA_W-1:0]        shadow_val[spq_pkg::CAPACITY_DEF];
    logic signed [spq_pkg::PRIO_W-1:0] shadow_prio[spq_pkg::CAPACITY_DEF];
    int                                shadow_cnt = 0;

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  accept_cnt = 0;
    int  hold_left = 0;
    logic held = 1'b0;

    sorted_priority_queue_core #(.CAPACITY(spq_pkg::CAPACITY_DEF)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .item_value    (item_value),
        .item_priority (item_priority),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .out_valid     (out_valid),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .entry_count   (entry_count)
    );

    always #5 clk = ~clk;

    // apply one push or pop to the shadow store, return the result it gives
    function automatic pq_res_t apply_to_shadow(pq_req_t r);
        pq_res_t res;
        int      pos;
        logic    found;
        res.status = spq_pkg::ST_DONE;
        res.hit    = 1'b0;
        res.value  = '0;
        res.prio   = '0;
        if (r.req == spq_pkg::REQ_PUSH)
        begin
            if (shadow_cnt >= spq_pkg::CAPACITY_DEF)
            begin
                res.status = spq_pkg::ST_FULL;
            end
            else
            begin
                // first slot whose priority is strictly lower
                pos   = shadow_cnt;
                found = 1'b0;
                for (int i = 0; i < shadow_cnt; i++)
                begin
                    if (!found && r.prio > shadow_prio[i])
                    begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (int i = shadow_cnt; i > pos; i--)
                begin
                    shadow_val[i]  = shadow_val[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_val[pos]  = r.value;
                shadow_prio[pos] = r.prio;
                shadow_cnt++;
            end
        end
        else
        begin
            if (shadow_cnt == 0)
            begin
                res.status = spq_pkg::ST_EMPTY_POP;
            end
            else
            begin
                res.hit   = 1'b1;
                res.value = shadow_val[0];
                res.prio  = shadow_prio[0];
                for (int i = 1; i < shadow_cnt; i++)
                begin
                    shadow_val[i-1]  = shadow_val[i];
                    shadow_prio[i-1] = shadow_prio[i];
                end
                shadow_cnt--;
            end
        end
        res.count = spq_pkg::COUNT_OUT_W'(shadow_cnt);
        return res;
    endfunction

    function automatic void queue_req(logic req, logic [spq_pkg::DATA_W-1:0] value,
                                      logic signed [spq_pkg::PRIO_W-1:0] prio);
        pq_req_t r;
        r.req   = req;
        r.value = value;
        r.prio  = prio;
        req_backlog.push_back(r);
    endfunction

    // mostly small priorities so ties are common, plus extremes and wide values
    function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_prio();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return spq_pkg::PRIO_W'($signed($urandom_range(6)) - 3);
        else if (sel < 60)
            return {1'b1, {(spq_pkg::PRIO_W-1){1'b0}}};
        else if (sel < 70)
            return {1'b0, {(spq_pkg::PRIO_W-1){1'b1}}};
        else
            return $urandom;
    endfunction

    function automatic logic calm();
        return accept_cnt >= CALM_FROM && accept_cnt < CALM_TO;
    endfunction

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // sender: offer items from the backlog, record expectations on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(apply_to_shadow(
                    pq_req_t'{req: req_type, value: item_value, prio: item_priority}));
                accept_cnt <= accept_cnt + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_backlog.size() > 0 &&
                    (calm() || hold_left > 0 || $urandom_range(99) >= 29))
                begin
                    req_type      <= req_backlog[0].req;
                    item_value    <= req_backlog[0].value;
                    item_priority <= req_backlog[0].prio;
                    in_valid      <= 1'b1;
                    void'(req_backlog.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, to back the core up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            held      <= 1'b0;
        end
        else if (!held && accept_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            held      <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: compare each accepted result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no item outstanding");
                    err_cnt++;
                end
                else
                begin
                    if (status !== pending_results[0].status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               pending_results[0].status, status);
                        err_cnt++;
                    end
                    if (out_valid !== pending_results[0].hit)
                    begin
                        $error("out_valid: expected %0d, actual %0d",
                               pending_results[0].hit, out_valid);
                        err_cnt++;
                    end
                    if (out_value !== pending_results[0].value)
                    begin
                        $error("out_value: expected %h, actual %h",
                               pending_results[0].value, out_value);
                        err_cnt++;
                    end
                    if (out_priority !== pending_results[0].prio)
                    begin
                        $error("out_priority: expected %0d, actual %0d",
                               pending_results[0].prio, out_priority);
                        err_cnt++;
                    end
                    if (entry_count !== pending_results[0].count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               pending_results[0].count, entry_count);
                        err_cnt++;
                    end
                    void'(pending_results.pop_front());
                end
            end
            res_stall <= hold_left > 0 || (!calm() && $urandom_range(99) < 29);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int push_pct;
        // pop on empty first
        queue_req(spq_pkg::REQ_POP, '0, '0);
        // fill to capacity: extremes, head and tail insertion, ties
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_0000, 32'sh8000_0000);
        queue_req(spq_pkg::REQ_PUSH, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_0001, 32'sd0);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_0002, 32'sd0);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_0003, -32'sd1);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_0004, 32'sh8000_0000);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_0005, 32'sh7FFF_FFFF);
        queue_req(spq_pkg::REQ_PUSH, 32'hAAAA_5555, 32'sd1);
        queue_req(spq_pkg::REQ_PUSH, 32'h5555_AAAA, -32'sd2);
        queue_req(spq_pkg::REQ_PUSH, 32'h8000_0000, 32'sd1);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_000B, 32'sh8000_0000);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_000C, 32'sh5A5A_A5A5);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_000D, 32'shA5A5_5A5A);
        queue_req(spq_pkg::REQ_PUSH, 32'h7FFF_FFFF, 32'sd0);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_000F, 32'sd2);
        queue_req(spq_pkg::REQ_PUSH, 32'h0000_0010, -32'sd1);
        // push into a full store
        queue_req(spq_pkg::REQ_PUSH, 32'hDEAD_0011, 32'sh7FFF_FFFF);
        // drain a few from the head
        repeat (5) queue_req(spq_pkg::REQ_POP, $urandom, $urandom);

        // random phases: fill-heavy, drain-heavy, then mixed
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            case ((n / PHASE_LEN) % 4)
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            if ($urandom_range(99) < push_pct)
                queue_req(spq_pkg::REQ_PUSH, $urandom, pick_prio());
            else
                queue_req(spq_pkg::REQ_POP, $urandom, $urandom);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
